// ===== rtl/core/vsla_pkg.sv =====
// Shared types and constants for the voxel shell lattice averager.
package vsla_pkg;

   localparam int DimDefault = 32;
   localparam int CountMax   = 65535;

   // Result status codes
   localparam logic [2:0] ST_ACCUM   = 3'd0;
   localparam logic [2:0] ST_SHELL   = 3'd1;
   localparam logic [2:0] ST_REJECT  = 3'd2;
   localparam logic [2:0] ST_RANGE   = 3'd3;
   localparam logic [2:0] ST_READ    = 3'd4;

   // Configuration register indexes
   localparam logic [2:0] CSR_INNER  = 3'd0;
   localparam logic [2:0] CSR_OUTER  = 3'd1;
   localparam logic [2:0] CSR_ORG_X  = 3'd2;
   localparam logic [2:0] CSR_ORG_Y  = 3'd3;
   localparam logic [2:0] CSR_ORG_Z  = 3'd4;
   localparam logic [2:0] CSR_MINOFF = 3'd5;
   localparam logic [2:0] CSR_MASK   = 3'd6;

   // Divider handshake
   typedef struct packed {
      logic        start;
      logic signed [48:0] num;
      logic [16:0] den;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic signed [31:0] quo;
   } div_rsp_type;

endpackage

// ===== rtl/core/vsla_divider.sv =====
// Restoring signed divider, one quotient bit per cycle, truncating toward zero.
module vsla_divider
   import vsla_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);
   localparam int NW = 49;

   logic [NW-1:0] quo_ff, quo_in;
   logic [16:0]   rem_ff, rem_in;
   logic [16:0]   den_ff, den_in;
   logic          neg_ff, neg_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [5:0]    cnt_ff, cnt_in;
   logic [17:0]   trial;
   logic [NW-1:0] qneg;

   // One shift-subtract step per cycle
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      trial   = {rem_ff, quo_ff[NW-1]} - {1'b0, den_ff};
      if (div_req.start) begin
         neg_in  = div_req.num[NW-1];
         quo_in  = div_req.num[NW-1] ? -div_req.num : div_req.num;
         rem_in  = '0;
         den_in  = div_req.den;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[17]) begin
            rem_in = trial[16:0];
            quo_in = {quo_ff[NW-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[15:0], quo_ff[NW-1]};
            quo_in = {quo_ff[NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'(NW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   assign qneg         = neg_ff ? -quo_ff : quo_ff;
   assign div_rsp.done = done_ff;
   assign div_rsp.quo  = qneg[31:0];
endmodule

// ===== rtl/core/voxel_shell_lattice_averager_unit.sv =====
// Voxel shell lattice averager: top level with sequencer, lattice stores and divider.
// Sequence: a read goes S_CHECK, S_READ (store read), S_OUT; an accumulate that reaches
//   the mean update adds S_MUL, S_DIV (49 divider steps); a rejection skips to S_OUT.
// Throughput: one request at a time; the next is taken once the response is taken.
// Reset: a clearing pass writes zero to all DIM_X*DIM_Y*DIM_Z cells (32768 by default) of
//   both stores, during which no request is accepted; control registers take reset values.
module voxel_shell_lattice_averager_unit
   import vsla_pkg::*;
#(
   parameter int DIM_X = DimDefault,
   parameter int DIM_Y = DimDefault,
   parameter int DIM_Z = DimDefault
)(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // [0] action, [1] unused
   input  logic [95:0] req_tdata,   // pos_x, pos_y, pos_z, sample_value, read_index, pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata    // status, cell_index, cell_mean, cell_count, pad
);
   localparam int  Cells = DIM_X * DIM_Y * DIM_Z;
   localparam int  AW    = (Cells > 1) ? $clog2(Cells) : 1;

   typedef enum logic [6:0] {
      S_CLEAR = 7'b0000001,
      S_IDLE  = 7'b0000010,
      S_CHECK = 7'b0000100,
      S_READ  = 7'b0001000,
      S_MUL   = 7'b0010000,
      S_DIV   = 7'b0100000,
      S_OUT   = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   // Configuration registers
   logic [31:0] inner_ff, outer_ff;
   logic [4:0]  orgx_ff, orgy_ff, orgz_ff;
   logic [7:0]  minoff_ff;
   logic signed [31:0] mask_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         inner_ff  <= 32'd0;
         outer_ff  <= 32'hC000_0000;
         orgx_ff   <= 5'd16;
         orgy_ff   <= 5'd16;
         orgz_ff   <= 5'd16;
         minoff_ff <= 8'd0;
         mask_ff   <= 32'sh8000_0000;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_INNER:  inner_ff  <= csr_wdata;
            CSR_OUTER:  outer_ff  <= csr_wdata;
            CSR_ORG_X:  orgx_ff   <= csr_wdata[4:0];
            CSR_ORG_Y:  orgy_ff   <= csr_wdata[4:0];
            CSR_ORG_Z:  orgz_ff   <= csr_wdata[4:0];
            CSR_MINOFF: minoff_ff <= csr_wdata[7:0];
            CSR_MASK:   mask_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Request fields
   logic signed [15:0] px, py, pz;
   logic signed [31:0] val;
   logic [14:0] ridx;
   assign px   = req_tdata[15:0];
   assign py   = req_tdata[31:16];
   assign pz   = req_tdata[47:32];
   assign val  = req_tdata[79:48];
   assign ridx = req_tdata[94:80];

   // Squared radius and per-axis rounding, captured at accept
   logic signed [31:0] sqx, sqy, sqz;
   logic [32:0] sq_sum;
   assign sqx    = px * px;
   assign sqy    = py * py;
   assign sqz    = pz * pz;
   assign sq_sum = 33'($unsigned(sqx)) + 33'($unsigned(sqy)) + 33'($unsigned(sqz));

   function automatic logic [16:0] round_axis(input logic signed [15:0] p,
                                              output logic [7:0] offs);
      logic [16:0] mag;
      logic [16:0] r;
      logic [16:0] d;
      mag  = p[15] ? -{p[15], p} : {p[15], p};
      r    = (mag + 17'd128) >> 8;
      d    = mag - (r << 8);
      offs = d[16] ? 8'(-d) : d[7:0];
      return p[15] ? -r : r;
   endfunction

   logic [32:0] sq_ff;
   logic        act_ff, badval_ff;
   logic [7:0]  dx_ff, dy_ff, dz_ff, dx_c, dy_c, dz_c;
   logic [16:0] hx_ff, hy_ff, hz_ff, hx_c, hy_c, hz_c;
   logic [14:0] ridx_ff;
   logic signed [31:0] val_ff;

   always_comb begin
      hx_c = round_axis(px, dx_c);
      hy_c = round_axis(py, dy_c);
      hz_c = round_axis(pz, dz_c);
   end

   // Cell coordinates
   logic signed [17:0] ci, cj, ck;
   logic        oor;
   logic [31:0] lin;
   assign ci  = $signed({hx_ff[16], hx_ff}) + $signed({13'd0, orgx_ff});
   assign cj  = $signed({hy_ff[16], hy_ff}) + $signed({13'd0, orgy_ff});
   assign ck  = $signed({hz_ff[16], hz_ff}) + $signed({13'd0, orgz_ff});
   assign oor = ci < 0 || ci >= 18'(DIM_X) || cj < 0 || cj >= 18'(DIM_Y)
             || ck < 0 || ck >= 18'(DIM_Z);
   assign lin = 32'(ck) * 32'(DIM_X * DIM_Y) + 32'(cj) * 32'(DIM_X) + 32'(ci);

   // Lattice stores
   logic signed [31:0] mean_mem [Cells];
   logic [15:0]        cnt_mem  [Cells];
   logic [AW-1:0]      addr_ff, addr_in;
   logic signed [31:0] mean_rd_ff;
   logic [15:0]        cnt_rd_ff;
   logic               we;
   logic signed [31:0] wmean;
   logic [15:0]        wcnt;

   always_ff @(posedge clock) begin
      if (we) begin
         mean_mem[addr_ff] <= wmean;
         cnt_mem[addr_ff]  <= wcnt;
      end
      mean_rd_ff <= mean_mem[addr_ff];
      cnt_rd_ff  <= cnt_mem[addr_ff];
   end

   // Divider
   div_req_type div_req;
   div_rsp_type div_rsp;
   vsla_divider u_div (.clock(clock), .reset(reset), .div_req(div_req), .div_rsp(div_rsp));

   logic signed [48:0] num_ff, num_in;
   logic signed [48:0] prod;
   logic [2:0]  st_ff, st_in;
   logic [14:0] oidx_ff, oidx_in;
   logic signed [31:0] omean_ff, omean_in;
   logic [15:0] ocnt_ff, ocnt_in;
   logic        rd_wait_ff, rd_wait_in;
   logic        accept;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_tdata  = {6'd0, ocnt_ff, omean_ff, oidx_ff, st_ff};

   // Weighted sum of the old mean, full width
   assign prod = $signed({1'b0, cnt_rd_ff}) * mean_rd_ff;

   // Sequencer
   always_comb begin
      state_in   = state_ff;
      addr_in    = addr_ff;
      num_in     = num_ff;
      st_in      = st_ff;
      oidx_in    = oidx_ff;
      omean_in   = omean_ff;
      ocnt_in    = ocnt_ff;
      rd_wait_in = rd_wait_ff;
      we         = 1'b0;
      wmean      = '0;
      wcnt       = '0;
      div_req    = '0;
      unique case (state_ff)
         S_CLEAR: begin
            we      = 1'b1;
            addr_in = addr_ff + AW'(1);
            if (32'(addr_ff) == 32'(Cells - 1)) state_in = S_IDLE;
         end
         S_IDLE: if (accept) state_in = S_CHECK;
         S_CHECK: begin
            st_in    = ST_ACCUM;
            oidx_in  = '0;
            omean_in = '0;
            ocnt_in  = '0;
            if (act_ff) begin
               if (32'(ridx_ff) >= 32'(Cells)) begin
                  st_in    = ST_RANGE;
                  state_in = S_OUT;
               end else begin
                  addr_in  = AW'(ridx_ff);
                  st_in    = ST_READ;
                  state_in = S_READ;
               end
            end else if (!(33'(inner_ff) < sq_ff && sq_ff < 33'(outer_ff))) begin
               st_in    = ST_SHELL;
               state_in = S_OUT;
            end else if (badval_ff || !(dx_ff > minoff_ff) || !(dy_ff > minoff_ff)
                         || !(dz_ff > minoff_ff)) begin
               st_in    = ST_REJECT;
               state_in = S_OUT;
            end else if (oor) begin
               st_in    = ST_RANGE;
               state_in = S_OUT;
            end else begin
               addr_in  = AW'(lin);
               state_in = S_READ;
            end
            rd_wait_in = 1'b1;
         end
         S_READ: begin
            rd_wait_in = 1'b0;
            if (!rd_wait_ff) begin
               oidx_in = 15'(addr_ff);
               if (st_ff == ST_READ) begin
                  omean_in = mean_rd_ff;
                  ocnt_in  = cnt_rd_ff;
                  state_in = S_OUT;
               end else state_in = S_MUL;
            end
         end
         S_MUL: begin
            num_in   = prod + 49'(val_ff);
            state_in = S_DIV;
            rd_wait_in = 1'b1;
         end
         S_DIV: begin
            rd_wait_in    = 1'b0;
            div_req.start = rd_wait_ff;
            div_req.num   = num_ff;
            div_req.den   = {1'b0, cnt_rd_ff} + 17'd1;
            if (div_rsp.done) begin
               we       = 1'b1;
               wmean    = div_rsp.quo;
               wcnt     = (cnt_rd_ff == 16'(CountMax)) ? cnt_rd_ff : cnt_rd_ff + 16'd1;
               omean_in = wmean;
               ocnt_in  = wcnt;
               state_in = S_OUT;
            end
         end
         S_OUT: if (rsp_tready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLEAR;
         addr_ff    <= '0;
         rd_wait_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         addr_ff    <= addr_in;
         rd_wait_ff <= rd_wait_in;
      end
      num_ff   <= num_in;
      st_ff    <= st_in;
      oidx_ff  <= oidx_in;
      omean_ff <= omean_in;
      ocnt_ff  <= ocnt_in;
      if (accept) begin
         act_ff    <= req_tuser[0];
         sq_ff     <= sq_sum;
         badval_ff <= (val == mask_ff) || (val == 32'sd0);
         dx_ff     <= dx_c;
         dy_ff     <= dy_c;
         dz_ff     <= dz_c;
         hx_ff     <= hx_c;
         hy_ff     <= hy_c;
         hz_ff     <= hz_c;
         ridx_ff   <= ridx;
         val_ff    <= val;
      end
   end
endmodule

// ===== verif/voxel_shell_lattice_averager_unit_tb.sv =====
// Self-checking testbench for the voxel shell lattice averager: scoreboard class and drivers.
`timescale 1ns / 100ps

module voxel_shell_lattice_averager_unit_tb
   import vsla_pkg::*;
();

   localparam int LAT_SIDE   = 32;
   localparam int IDLE_LIMIT = 200000;   // covers the clearing pass and the longest stall
   localparam int DRAIN_WAIT = 80;

   typedef struct packed {
      logic               action;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic signed [15:0] pos_z;
      logic signed [31:0] sample;
      logic [14:0]        read_index;
   } voxel_req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic [14:0]        cell_idx;
      logic signed [31:0] mean;
      logic [15:0]        count;
   } cell_rsp_type;

   // Scoreboard: lattice mirror, shadow registers and the pending responses
   class lattice_scoreboard;
      int            mean_mem[int];
      int            count_mem[int];
      logic [31:0]   inner_sq, outer_sq;
      int            org_x, org_y, org_z;
      int            min_off;
      logic [31:0]   mask_val;
      cell_rsp_type  pending[$];
      int            errors;

      function new();
         inner_sq = 32'd0;
         outer_sq = 32'hC000_0000;
         org_x = 16; org_y = 16; org_z = 16;
         min_off = 0;
         mask_val = 32'h8000_0000;
         errors = 0;
      endfunction

      function void write_reg(logic [2:0] idx, logic [31:0] v);
         case (idx)
            CSR_INNER:  inner_sq = v;
            CSR_OUTER:  outer_sq = v;
            CSR_ORG_X:  org_x = int'(v[4:0]);
            CSR_ORG_Y:  org_y = int'(v[4:0]);
            CSR_ORG_Z:  org_z = int'(v[4:0]);
            CSR_MINOFF: min_off = int'(v[7:0]);
            CSR_MASK:   mask_val = v;
            default: ;
         endcase
      endfunction

      // Round half away from zero; offs is |p - round(p)| in Q0.8
      function int round_axis(int p, output int offs);
         int mag, r;
         mag = (p < 0) ? -p : p;
         r = (mag + 128) / 256;
         offs = mag - r * 256;
         if (offs < 0) offs = -offs;
         return (p < 0) ? -r : r;
      endfunction

      function void note_request(voxel_req_type r);
         cell_rsp_type  e;
         longint        q2, num;
         int            px, py, pz, dx, dy, dz, ci, cj, ck, idx, cnt, mean_now;
         e = '0;
         px = int'(r.pos_x); py = int'(r.pos_y); pz = int'(r.pos_z);
         if (r.action) begin
            idx = int'(r.read_index);
            e.status = ST_READ;
            e.cell_idx = r.read_index;
            e.mean = mean_mem.exists(idx) ? mean_mem[idx] : 0;
            e.count = 16'(count_mem.exists(idx) ? count_mem[idx] : 0);
         end else begin
            q2 = longint'(px) * px + longint'(py) * py + longint'(pz) * pz;
            ci = round_axis(px, dx) + org_x;
            cj = round_axis(py, dy) + org_y;
            ck = round_axis(pz, dz) + org_z;
            if (!(longint'(inner_sq) < q2 && q2 < longint'(outer_sq))) begin
               e.status = ST_SHELL;
            end else if (r.sample == mask_val || r.sample == 0 ||
                         dx <= min_off || dy <= min_off || dz <= min_off) begin
               e.status = ST_REJECT;
            end else if (ci < 0 || ci >= LAT_SIDE || cj < 0 || cj >= LAT_SIDE ||
                         ck < 0 || ck >= LAT_SIDE) begin
               e.status = ST_RANGE;
            end else begin
               idx = ck * LAT_SIDE * LAT_SIDE + cj * LAT_SIDE + ci;
               cnt = count_mem.exists(idx) ? count_mem[idx] : 0;
               mean_now = mean_mem.exists(idx) ? mean_mem[idx] : 0;
               num = longint'(cnt) * mean_now + longint'(r.sample);
               mean_mem[idx] = int'(num / longint'(cnt + 1));
               if (cnt < CountMax) count_mem[idx] = cnt + 1;
               else count_mem[idx] = cnt;
               e.status = ST_ACCUM;
               e.cell_idx = idx[14:0];
               e.mean = mean_mem[idx];
               e.count = 16'(count_mem[idx]);
            end
         end
         pending.push_back(e);
      endfunction

      function void check_response(cell_rsp_type a);
         cell_rsp_type e;
         if (pending.size() == 0) begin
            $display("%0t: response with none pending: %p", $time, a);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (a.status !== e.status) begin
            $display("%0t: status exp %0d got %0d", $time, e.status, a.status);
            errors++;
         end
         if (a.cell_idx !== e.cell_idx) begin
            $display("%0t: cell_index exp %0d got %0d", $time, e.cell_idx, a.cell_idx);
            errors++;
         end
         if (a.mean !== e.mean) begin
            $display("%0t: cell_mean exp %0d got %0d", $time, e.mean, a.mean);
            errors++;
         end
         if (a.count !== e.count) begin
            $display("%0t: cell_count exp %0d got %0d", $time, e.count, a.count);
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [31:0] csr_wdata;
   logic        req_tvalid;
   logic        req_tready;
   logic [1:0]  req_tuser;    // [0] action, [1] unused
   logic [95:0] req_tdata;    // pos_x, pos_y, pos_z, sample_value, read_index, pad
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [71:0] rsp_tdata;    // status, cell_index, cell_mean, cell_count, pad

   lattice_scoreboard lattice_sb;
   int burst_left;
   int idle_cycles;
   int hot_cell[4][3];

   voxel_shell_lattice_averager_unit DUT (.*);

   // Clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Input monitor: every accepted request goes to the scoreboard
   always @(posedge clock) begin
      voxel_req_type r;
      if (!reset && req_tvalid && req_tready) begin
         r.action = req_tuser[0];
         r.pos_x = req_tdata[15:0];
         r.pos_y = req_tdata[31:16];
         r.pos_z = req_tdata[47:32];
         r.sample = req_tdata[79:48];
         r.read_index = req_tdata[94:80];
         lattice_sb.note_request(r);
      end
   end

   // Output monitor
   always @(posedge clock) begin
      cell_rsp_type a;
      if (!reset && rsp_tvalid && rsp_tready) begin
         a.status = rsp_tdata[2:0];
         a.cell_idx = rsp_tdata[17:3];
         a.mean = rsp_tdata[49:18];
         a.count = rsp_tdata[65:50];
         lattice_sb.check_response(a);
      end
   end

   // Receiver stall pattern: runs of always-ready, random, and long stalls
   always @(posedge clock) begin
      int mode, left;
      if (left <= 0) begin
         mode = $urandom_range(0, 3);
         left = $urandom_range(20, 300);
      end
      left--;
      case (mode)
         0, 1: rsp_tready <= 1'b1;
         2:    rsp_tready <= ($urandom_range(0, 1) == 1);
         default: rsp_tready <= ($urandom_range(0, 15) == 0);
      endcase
   end

   // Watchdog on cycles with no transfer on either side
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IDLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Write enable is left high; the caller drops it after the last write
   task automatic write_csr(logic [2:0] idx, logic [31:0] v);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      lattice_sb.write_reg(idx, v);
   endtask

   // Bursty sender: valid stays up inside a burst, drops for a random gap after it
   task automatic send_req(voxel_req_type r);
      if (burst_left <= 0) burst_left = $urandom_range(1, 12);
      req_tvalid <= 1'b1;
      req_tuser <= {1'b0, r.action};
      req_tdata <= {1'b0, r.read_index, r.sample, r.pos_z, r.pos_y, r.pos_x};
      do @(posedge clock); while (!req_tready);
      burst_left--;
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 20)) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (lattice_sb.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   // One axis of a position on cell c with a legal offset, when min_off is below 127
   function automatic logic [15:0] axis_pos(int c, int org);
      int hx, d;
      hx = c - org;
      d = (lattice_sb.min_off >= 127) ? $urandom_range(0, 128)
                                      : $urandom_range(lattice_sb.min_off + 1, 127);
      return 16'(hx * 256 + ($urandom_range(0, 1) ? d : -d));
   endfunction

   function automatic voxel_req_type make_random();
      voxel_req_type r;
      int sel, c[3];
      r = '0;
      r.pos_x = 16'($urandom); r.pos_y = 16'($urandom); r.pos_z = 16'($urandom);
      r.sample = $urandom;
      r.read_index = 15'($urandom);
      sel = $urandom_range(0, 99);
      if (sel < 15) begin
         r.action = 1'b1;
         if (sel < 10) begin
            c = hot_cell[$urandom_range(0, 3)];
            r.read_index = 15'(c[2] * 1024 + c[1] * 32 + c[0]);
         end
      end else if (sel < 85) begin
         if (sel < 50) c = hot_cell[$urandom_range(0, 3)];
         else foreach (c[k]) c[k] = $urandom_range(0, 31);
         if (sel % 17 == 0) c[$urandom_range(0, 2)] = $urandom_range(0, 1) ? -1 : 32;
         r.pos_x = axis_pos(c[0], lattice_sb.org_x);
         r.pos_y = axis_pos(c[1], lattice_sb.org_y);
         r.pos_z = axis_pos(c[2], lattice_sb.org_z);
         if (sel % 5 == 0) r.sample = 32'($signed(16'($urandom))) <<< 8;
         if (sel % 23 == 0) r.sample = lattice_sb.mask_val;
         if (sel % 29 == 0) r.sample = 0;
      end
      return r;
   endfunction

   function automatic voxel_req_type accum(int px, int py, int pz, int v);
      voxel_req_type r;
      r = '0;
      r.pos_x = 16'(px); r.pos_y = 16'(py); r.pos_z = 16'(pz);
      r.sample = v;
      return r;
   endfunction

   function automatic voxel_req_type read_cell(int idx);
      voxel_req_type r;
      r = '0;
      r.action = 1'b1;
      r.read_index = 15'(idx);
      r.pos_x = 16'h7fff; r.sample = 32'h1234_5678;
      return r;
   endfunction

   // Runs one setting of the registers with a batch of random requests
   task automatic run_phase(logic [31:0] inner, logic [31:0] outer, int ox, int oy, int oz,
                            int moff, logic [31:0] mask, int items);
      drain();
      write_csr(CSR_INNER, inner);
      write_csr(CSR_OUTER, outer);
      write_csr(CSR_ORG_X, ox);
      write_csr(CSR_ORG_Y, oy);
      write_csr(CSR_ORG_Z, oz);
      write_csr(CSR_MINOFF, moff);
      write_csr(CSR_MASK, mask);
      csr_we <= 1'b0;
      foreach (hot_cell[h, k]) hot_cell[h][k] = $urandom_range(0, 31);
      hot_cell[0] = '{0, 0, 0};
      hot_cell[1] = '{31, 31, 31};
      repeat (items) send_req(make_random());
   endtask

   // Main sequence
   initial begin
      lattice_sb = new();
      reset = 1'b1;
      csr_we = 1'b0; csr_index = '0; csr_wdata = '0;
      req_tvalid = 1'b0; req_tuser = '0; req_tdata = '0;
      rsp_tready = 1'b0;
      burst_left = 0;
      idle_cycles = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: reset-value registers
      send_req(read_cell(0));
      send_req(read_cell(32767));
      send_req(accum(0, 0, 0, 100));                       // on the inner radius: shell
      send_req(accum(-32768, -32768, -32768, 5));          // squared radius equals outer
      send_req(accum(32767, -32768, 32767, 5));            // just inside outer, zero offset on y: reject
      send_req(accum(300, 200, -100, 32'h8000_0000));      // mask tag
      send_req(accum(300, 200, -100, 0));                  // zero value
      send_req(accum(256, 200, -100, 7));                  // exact integer: zero offset
      send_req(accum(300, 200, -100, 32'h7fff_ffff));
      send_req(accum(300, 200, -100, 32'h8000_0001));
      send_req(accum(300, 200, -100, -12345));
      send_req(accum(384, -384, 128, 65536));              // halves round away from zero
      send_req(accum(-4096 - 100, -4096 - 100, -4096 - 100, 3));   // lowest cell
      send_req(accum(3968 + 60, 3968 + 60, 3968 + 60, -3));       // rounds to cell 32: out of range
      send_req(accum(4096 + 60, 100, 100, 9));             // cell 32: out of range
      send_req(accum(-4224 - 60, 100, 100, 9));            // cell -1: out of range
      send_req(read_cell(16 * 1024 + 17 * 32 + 17));
      send_req(read_cell(0));
      send_req(read_cell(32767));

      run_phase(32'd0, 32'hC000_0000, 16, 16, 16, 0, 32'h8000_0000, 160);
      run_phase(32'h0001_0000, 32'h0100_0000, 0, 31, 5, 64, $urandom, 180);
      run_phase(32'hC000_0000, 32'd0, 31, 0, 16, 10, 32'h7fff_ffff, 25);
      run_phase(32'd0, 32'hC000_0000, $urandom_range(0, 31), $urandom_range(0, 31),
                $urandom_range(0, 31), 128, $urandom, 25);
      run_phase(32'd5, 32'hBFFF_FFFF, $urandom_range(0, 31), $urandom_range(0, 31),
                $urandom_range(0, 31), 127, $urandom, 40);
      run_phase(32'd0, 32'hC000_0000, 16, 16, 16, $urandom_range(0, 40), 32'd0, 300);

      drain();
      if (lattice_sb.errors == 0 && lattice_sb.pending.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
